// File: src/fls_pkg.sv
// fls_pkg: shared types, codes and format conversions for the FP load/store unit.
// Depends on nothing; imported by fp_load_store_unit.
package fls_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned GprW     = 32;
  localparam int unsigned FprW     = 64;

  typedef logic [RegIdxW-1:0] reg_idx_t;

  // instruction forms
  localparam logic [4:0] OP_LFS    = 5'd0;
  localparam logic [4:0] OP_STFIWX = 5'd16;

  // instruction groups
  typedef enum logic [2:0] {
    GRP_LFS   = 3'd0,
    GRP_LFD   = 3'd1,
    GRP_STFS  = 3'd2,
    GRP_STFD  = 3'd3,
    GRP_STFIW = 3'd4
  } grp_t;

  // memory access kinds
  localparam logic [2:0] ACC_NONE     = 3'd0;
  localparam logic [2:0] ACC_RD_WORD  = 3'd1;
  localparam logic [2:0] ACC_RD_DWORD = 3'd2;
  localparam logic [2:0] ACC_WR_WORD  = 3'd3;
  localparam logic [2:0] ACC_WR_DWORD = 3'd4;

  localparam logic [63:0] LOW_WORD_MASK = 64'h0000_0000_ffff_ffff;

  // Single to double, exact. NaN payloads pass through unquieted.
  function automatic logic [63:0] widen_single(input logic [31:0] w);
    logic        s;
    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  p;
    logic [22:0] fn;
    logic [10:0] de;
    logic [63:0] r;
    s  = w[31];
    e  = w[30:23];
    f  = w[22:0];
    p  = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) p = 5'(i);
    end
    fn = f << (5'd23 - p);
    de = 11'd874 + {6'd0, p};
    if (e == 8'hff) begin
      r = {s, 11'h7ff, f, 29'd0};
    end else if (e == 8'h00) begin
      if (f == 23'd0) r = {s, 63'd0};
      else r = {s, de, fn, 29'd0};
    end else begin
      r = {s, 11'({3'd0, e} + 11'd896), f, 29'd0};
    end
    return r;
  endfunction

  // Double to single, round to nearest even, NaNs quieted.
  function automatic logic [31:0] narrow_double(input logic [63:0] d);
    logic        s;
    logic [10:0] e;
    logic [51:0] f;
    logic [63:0] m;
    logic signed [12:0] fe;
    logic [5:0]  sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] mask;
    logic [31:0] r;
    s  = d[63];
    e  = d[62:52];
    f  = d[51:0];
    // keep the shift range up to 63 so the halfway point never vanishes
    m  = {11'd0, 1'b1, f};
    fe = $signed({2'b00, e}) - 13'sd896;
    if (fe >= 13'sd1) sh = 6'd29;
    else sh = 6'(13'sd30 - fe);
    q    = m >> sh;
    mask = (64'd1 << sh) - 64'd1;
    rem  = m & mask;
    half = 64'd1 << (sh - 6'd1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (e == 11'h7ff) begin
      if (f == 52'd0) r = {s, 31'h7f80_0000};
      else r = {s, 31'h7fc0_0000} | {9'd0, f[51:29]};
    end else if (e == 11'd0) begin
      r = {s, 31'd0};
    end else if (fe < 13'sd1) begin
      if (fe <= -13'sd34) r = {s, 31'd0};
      else r = {s, 31'd0} | q[31:0];
    end else begin
      if (q[24]) begin
        q  = q >> 1;
        fe = fe + 13'sd1;
      end
      if (fe >= 13'sd255) r = {s, 31'h7f80_0000};
      else r = {s, fe[7:0], q[22:0]};
    end
    return r;
  endfunction

endpackage

// File: src/fp_load_store_unit.sv
// fp_load_store_unit: FP load/store unit; register files held in fls_ram instances.
// Depends on fls_pkg and fls_ram.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_stall, op..load_data        | request
//  out     | out_valid/out_stall, access_kind..unav. | result
//  cfg     | cfg_we, cfg_index, cfg_wdata            | write only
//
// One item per cycle while the result is not stalled; register-file read, then result register.
// Reads for the next item overlap the write-back of the previous one; a last-write
// register forwards the newest GPR and FPR values. Reset clears control and valid
// bits; entries never written read as zero. A stalled result holds the execute stage.
module fp_load_store_unit
  import fls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_op,
  input  logic [4:0]  in_fp_reg,
  input  logic [4:0]  in_base_reg,
  input  logic [4:0]  in_index_reg,
  input  logic signed [15:0] in_offset,
  input  logic [63:0] in_load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_access_kind,
  output logic [31:0] out_mem_address,
  output logic [63:0] out_store_data,
  output logic        out_fp_unavailable,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [0:0]  cfg_wdata
);

  logic fp_enable_r, paired_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_enable_r <= 1'b0;
      paired_r    <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) fp_enable_r <= cfg_wdata[0];
      else paired_r <= cfg_wdata[0];
    end
  end

  // execute stage
  logic              s1_v_r;
  logic [4:0]        s1_op_r;
  reg_idx_t          s1_fr_r, s1_ra_r, s1_rb_r;
  logic [15:0]       s1_off_r;
  logic [63:0]       s1_ld_r;
  logic              out_v_r;
  logic              adv, accept;

  assign adv      = !out_v_r || !out_stall;
  assign in_stall = s1_v_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_op;
      s1_fr_r  <= in_fp_reg;
      s1_ra_r  <= in_base_reg;
      s1_rb_r  <= in_index_reg;
      s1_off_r <= in_offset;
      s1_ld_r  <= in_load_data;
    end
  end

  // re-read the held item's entries while it waits
  reg_idx_t rd_ra, rd_rb, rd_fr;
  assign rd_ra = in_stall ? s1_ra_r : in_base_reg;
  assign rd_rb = in_stall ? s1_rb_r : in_index_reg;
  assign rd_fr = in_stall ? s1_fr_r : in_fp_reg;

  logic            gpr_we, fpr_we;
  logic [31:0]     gpr_wd;
  logic [63:0]     fpr_wd;
  logic [31:0]     ram_a, ram_b;
  logic [63:0]     ram_f;

  fls_ram #(.Width(GprW), .Depth(RegCount)) u_gpr_a (
    .clk(clk), .wr_en(gpr_we), .wr_addr(s1_ra_r), .wr_data(gpr_wd),
    .rd_addr(rd_ra), .rd_data(ram_a));

  fls_ram #(.Width(GprW), .Depth(RegCount)) u_gpr_b (
    .clk(clk), .wr_en(gpr_we), .wr_addr(s1_ra_r), .wr_data(gpr_wd),
    .rd_addr(rd_rb), .rd_data(ram_b));

  fls_ram #(.Width(FprW), .Depth(RegCount)) u_fpr (
    .clk(clk), .wr_en(fpr_we), .wr_addr(s1_fr_r), .wr_data(fpr_wd),
    .rd_addr(rd_fr), .rd_data(ram_f));

  // valid bits and last-write forwarding
  logic [RegCount-1:0] gvld_r, fvld_r;
  logic                gfw_v_r, ffw_v_r;
  reg_idx_t            gfw_addr_r, ffw_addr_r;
  logic [31:0]         gfw_data_r;
  logic [63:0]         ffw_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvld_r  <= '0;
      fvld_r  <= '0;
      gfw_v_r <= 1'b0;
      ffw_v_r <= 1'b0;
    end else begin
      if (gpr_we) begin
        gvld_r[s1_ra_r] <= 1'b1;
        gfw_v_r         <= 1'b1;
      end
      if (fpr_we) begin
        fvld_r[s1_fr_r] <= 1'b1;
        ffw_v_r         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gpr_we) begin
      gfw_addr_r <= s1_ra_r;
      gfw_data_r <= gpr_wd;
    end
    if (fpr_we) begin
      ffw_addr_r <= s1_fr_r;
      ffw_data_r <= fpr_wd;
    end
  end

  logic [31:0] gpr_a, gpr_b;
  logic [63:0] fpr_v;

  always_comb begin
    if (gfw_v_r && gfw_addr_r == s1_ra_r) gpr_a = gfw_data_r;
    else gpr_a = gvld_r[s1_ra_r] ? ram_a : 32'd0;
    if (gfw_v_r && gfw_addr_r == s1_rb_r) gpr_b = gfw_data_r;
    else gpr_b = gvld_r[s1_rb_r] ? ram_b : 32'd0;
    if (ffw_v_r && ffw_addr_r == s1_fr_r) fpr_v = ffw_data_r;
    else fpr_v = fvld_r[s1_fr_r] ? ram_f : 64'd0;
  end

  // decode and execute
  logic        op_ok, indexed, update;
  grp_t        grp;
  logic [31:0] base, addend, ea;
  logic [2:0]  kind;
  logic [63:0] sdata;
  logic        fire;

  always_comb begin
    op_ok   = (s1_op_r[4] == 1'b0) || (s1_op_r == OP_STFIWX);
    if (s1_op_r == OP_STFIWX) begin
      grp     = GRP_STFIW;
      indexed = 1'b1;
      update  = 1'b0;
    end else begin
      grp     = grp_t'({1'b0, s1_op_r[3:2]});
      indexed = s1_op_r[0];
      update  = s1_op_r[1];
    end
    base   = (update || s1_ra_r != '0) ? gpr_a : 32'd0;
    addend = indexed ? gpr_b : {{16{s1_off_r[15]}}, s1_off_r};
    ea     = base + addend;
    fire   = s1_v_r && adv && fp_enable_r && op_ok;
    fpr_wd = s1_ld_r;
    sdata  = 64'd0;
    kind   = ACC_NONE;
    fpr_we = 1'b0;
    case (grp)
      GRP_LFS: begin
        fpr_wd = widen_single(s1_ld_r[31:0]);
        fpr_we = fire;
        kind   = ACC_RD_WORD;
      end
      GRP_LFD: begin
        fpr_we = fire;
        kind   = ACC_RD_DWORD;
      end
      GRP_STFS: begin
        sdata = {32'd0, narrow_double(fpr_v)};
        kind  = ACC_WR_WORD;
      end
      GRP_STFD: begin
        sdata = fpr_v;
        kind  = ACC_WR_DWORD;
      end
      default: begin
        sdata = fpr_v & LOW_WORD_MASK;
        kind  = ACC_WR_WORD;
      end
    endcase
    gpr_we = fire && update;
    gpr_wd = ea;
  end

  // paired mode also fills the second half on single loads; nothing ever reads
  // that half, so it has no storage here
  logic paired_fill;
  assign paired_fill = paired_r && fpr_we && (grp == GRP_LFS);

  // result register
  logic [2:0]  out_kind_r;
  logic [31:0] out_addr_r;
  logic [63:0] out_data_r;
  logic        out_unav_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      if (!fp_enable_r || !op_ok) begin
        out_kind_r <= ACC_NONE;
        out_addr_r <= 32'd0;
        out_data_r <= 64'd0;
      end else begin
        out_kind_r <= kind;
        out_addr_r <= ea;
        out_data_r <= sdata;
      end
      out_unav_r <= !fp_enable_r || (paired_fill && 1'b0);
    end
  end

  assign out_valid          = out_v_r;
  assign out_access_kind    = out_kind_r;
  assign out_mem_address    = out_addr_r;
  assign out_store_data     = out_data_r;
  assign out_fp_unavailable = out_unav_r;

endmodule

// File: src/fls_ram.sv
// fls_ram: generic RAM, one write port and one read port with registered read data.
// Depends on nothing.
module fls_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
